// File: rtl/core/assert_macros.svh
// Assertion macros shared by the frame averager RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds at every clock edge outside reset.
`define FFA_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that a condition implies another one in the same cycle.
`define FFA_ASSERT_IMPL(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);

`endif

// File: rtl/core/ffa_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the frame averager.
package ffa_pkg;

    localparam int SAMPLE_WIDTH = 16;
    localparam int CHANNELS     = 9;
    // one stored frame: valid mark on top, then accel, gyro, mag x/y/z
    localparam int WORD_W       = CHANNELS * SAMPLE_WIDTH + 1;

    localparam logic MODE_PUSH = 1'b0;
    localparam logic MODE_TAKE = 1'b1;

    localparam logic [1:0] ST_PUSHED  = 2'd0;
    localparam logic [1:0] ST_DROPPED = 2'd1;
    localparam logic [1:0] ST_AVG     = 2'd2;
    localparam logic [1:0] ST_NONE    = 2'd3;

    localparam logic [SAMPLE_WIDTH-1:0] S_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    localparam logic [SAMPLE_WIDTH-1:0] S_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

    typedef struct packed {
        logic                           mode;
        logic                           frame_valid;
        logic signed [SAMPLE_WIDTH-1:0] accel_x;
        logic signed [SAMPLE_WIDTH-1:0] accel_y;
        logic signed [SAMPLE_WIDTH-1:0] accel_z;
        logic signed [SAMPLE_WIDTH-1:0] gyro_x;
        logic signed [SAMPLE_WIDTH-1:0] gyro_y;
        logic signed [SAMPLE_WIDTH-1:0] gyro_z;
        logic signed [SAMPLE_WIDTH-1:0] mag_x;
        logic signed [SAMPLE_WIDTH-1:0] mag_y;
        logic signed [SAMPLE_WIDTH-1:0] mag_z;
    } t_in;

    typedef struct packed {
        logic [1:0]                     status;
        logic signed [SAMPLE_WIDTH-1:0] avg_accel_x;
        logic signed [SAMPLE_WIDTH-1:0] avg_accel_y;
        logic signed [SAMPLE_WIDTH-1:0] avg_accel_z;
        logic signed [SAMPLE_WIDTH-1:0] avg_gyro_x;
        logic signed [SAMPLE_WIDTH-1:0] avg_gyro_y;
        logic signed [SAMPLE_WIDTH-1:0] avg_gyro_z;
        logic signed [SAMPLE_WIDTH-1:0] avg_mag_x;
        logic signed [SAMPLE_WIDTH-1:0] avg_mag_y;
        logic signed [SAMPLE_WIDTH-1:0] avg_mag_z;
    } t_out;

    // per-cycle commands from the sequencer to every channel lane
    typedef struct packed {
        logic clr;
        logic acc;
        logic load;
        logic step;
    } t_lane_ctrl;

endpackage

// File: rtl/core/ffa_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM with one write port and a registered read.
module ffa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: rtl/core/ffa_lane.sv
`timescale 1ns / 1ps
// One channel lane: running sum, then a bit-serial rounded divide by the frame count.
module ffa_lane #(
    parameter int CNT_W = 3
) (
    input  logic                                   i_clk,
    input  ffa_pkg::t_lane_ctrl                    i_ctrl,
    input  logic signed [ffa_pkg::SAMPLE_WIDTH-1:0] i_sample,
    input  logic [CNT_W-1:0]                       i_cnt,
    output logic signed [ffa_pkg::SAMPLE_WIDTH-1:0] o_mean
);
    import ffa_pkg::*;

    localparam int SUM_W = SAMPLE_WIDTH + CNT_W;
    localparam int NUM_W = SUM_W + 1;
    localparam int DEN_W = CNT_W + 1;
    localparam logic [NUM_W-1:0] Q_HI  = (NUM_W'(1) << (SAMPLE_WIDTH - 1)) - NUM_W'(1);
    localparam logic [NUM_W-1:0] Q_LIM = Q_HI + NUM_W'(1);

    logic signed [SUM_W-1:0] r_sum;
    logic [NUM_W-1:0]        r_num;
    logic [NUM_W-1:0]        r_quo;
    logic [DEN_W-1:0]        r_rem;
    logic [DEN_W-1:0]        r_den;
    logic                    r_neg;

    logic [SUM_W-1:0]        w_mag;
    logic [DEN_W:0]          w_trial;
    logic [DEN_W:0]          w_diff;
    logic                    w_ge;

    always_comb begin
        w_mag   = r_sum[SUM_W-1] ? ('0 - $unsigned(r_sum)) : $unsigned(r_sum);
        w_trial = {r_rem, r_num[NUM_W-1]};
        w_ge    = (w_trial >= {1'b0, r_den});
        w_diff  = w_trial - {1'b0, r_den};
    end

    // quotient of (2|sum| + n) / 2n is the mean rounded half away from zero
    always_ff @(posedge i_clk) begin
        if (i_ctrl.clr) begin
            r_sum <= '0;
        end else if (i_ctrl.acc) begin
            r_sum <= r_sum + SUM_W'(i_sample);
        end
        if (i_ctrl.load) begin
            r_num <= {w_mag, 1'b0} + NUM_W'(i_cnt);
            r_den <= {i_cnt, 1'b0};
            r_rem <= '0;
            r_quo <= '0;
            r_neg <= r_sum[SUM_W-1];
        end else if (i_ctrl.step) begin
            r_num <= {r_num[NUM_W-2:0], 1'b0};
            r_rem <= w_ge ? w_diff[DEN_W-1:0] : w_trial[DEN_W-1:0];
            r_quo <= {r_quo[NUM_W-2:0], w_ge};
        end
    end

    always_comb begin
        if (!r_neg) begin
            o_mean = (r_quo > Q_HI) ? $signed(S_MAX) : $signed(r_quo[SAMPLE_WIDTH-1:0]);
        end else begin
            o_mean = (r_quo > Q_LIM) ? $signed(S_MIN)
                                     : $signed('0 - r_quo[SAMPLE_WIDTH-1:0]);
        end
    end
endmodule

// File: rtl/core/frame_fifo_drop_oldest_averager_top.sv
`timescale 1ns / 1ps
// Frame averager top level: a ring buffer of QUEUE_DEPTH nine-channel motion
// frames held in one RAM (one write and one registered read port), with a
// drain-and-average command. A push transfer stores a frame at the write slot
// and gives its result in the output register in the next cycle; when the buffer
// is already full the oldest frame is dropped and status reports it. A take
// transfer reads the stored frames oldest first, one RAM read per cycle, sums
// the valid ones in nine channel lanes, then divides every lane at once by the
// frame count with a restoring divider that settles one quotient bit a cycle.
// How long a take lasts is set by the RAM read port during the drain and
// by the bit-serial divide after.
// Means are rounded to nearest with ties away from zero and saturated; status
// 3 with zero means reports a take that found no valid frame. One item is
// worked on at a time; a new transfer is taken while the previous result sits
// in the output register, provided that register is empty or is being read.
// Writes and reads of the RAM never fall in the same cycle, so no forwarding
// is needed, and no clearing pass runs after reset.
module frame_fifo_drop_oldest_averager_top #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  ffa_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output ffa_pkg::t_out o_out_data
);
    import ffa_pkg::*;
    `include "assert_macros.svh"

    localparam int AW    = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int NUM_W = SAMPLE_WIDTH + CNT_W + 1;
    localparam int DCW   = $clog2(NUM_W);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_DRAIN = 2'd1;
    localparam logic [1:0] S_DIV   = 2'd2;
    localparam logic [1:0] S_FIN   = 2'd3;

    logic [1:0]       r_state, n_state;
    logic [AW-1:0]    r_wr_slot, n_wr_slot;
    logic [AW-1:0]    r_rd_slot, n_rd_slot;
    logic [CNT_W-1:0] r_fill, n_fill;
    logic [CNT_W-1:0] r_left, n_left;
    logic [CNT_W-1:0] r_n, n_n;
    logic             r_rd_pend, n_rd_pend;
    logic [DCW-1:0]   r_div_cnt, n_div_cnt;
    logic             r_out_valid, n_out_valid;
    t_out             r_out_data, n_out_data;

    logic             w_in_acc;
    logic             w_out_free;
    logic             w_push;
    logic             w_rd_issue;
    logic [WORD_W-1:0] w_wdata;
    logic [WORD_W-1:0] w_rdata;
    logic [AW-1:0]    w_wr_inc;
    logic [AW-1:0]    w_rd_inc;
    t_lane_ctrl       w_ctrl;
    logic signed [SAMPLE_WIDTH-1:0] w_mean [CHANNELS];
    logic [CHANNELS*SAMPLE_WIDTH-1:0] w_mean_flat;

    assign w_out_free = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE) && w_out_free;
    assign w_in_acc   = i_in_valid && o_in_ready;
    assign w_push     = w_in_acc && (i_in_data.mode == MODE_PUSH);
    assign w_rd_issue = (r_state == S_DRAIN) && (r_left != '0);

    assign w_wr_inc = (r_wr_slot == AW'(QUEUE_DEPTH - 1)) ? '0 : r_wr_slot + 1'b1;
    assign w_rd_inc = (r_rd_slot == AW'(QUEUE_DEPTH - 1)) ? '0 : r_rd_slot + 1'b1;

    assign w_wdata = {i_in_data.frame_valid,
                      i_in_data.accel_x, i_in_data.accel_y, i_in_data.accel_z,
                      i_in_data.gyro_x,  i_in_data.gyro_y,  i_in_data.gyro_z,
                      i_in_data.mag_x,   i_in_data.mag_y,   i_in_data.mag_z};

    ffa_ram #(
        .WIDTH (WORD_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_push),
        .i_waddr (r_wr_slot),
        .i_wdata (w_wdata),
        .i_raddr (r_rd_slot),
        .o_rdata (w_rdata)
    );

    // lane commands: clear on take, add each valid frame as it leaves the RAM,
    // load the divider once the drain is over, then step it
    always_comb begin
        w_ctrl.clr  = w_in_acc && (i_in_data.mode == MODE_TAKE);
        w_ctrl.acc  = r_rd_pend && w_rdata[WORD_W-1];
        w_ctrl.load = (r_state == S_DRAIN) && (r_left == '0) && !r_rd_pend
                      && (r_n != '0);
        w_ctrl.step = (r_state == S_DIV);
    end

    for (genvar c = 0; c < CHANNELS; c++) begin : g_lane
        ffa_lane #(
            .CNT_W (CNT_W)
        ) u_lane (
            .i_clk    (i_clk),
            .i_ctrl   (w_ctrl),
            .i_sample ($signed(w_rdata[(CHANNELS-1-c)*SAMPLE_WIDTH +: SAMPLE_WIDTH])),
            .i_cnt    (r_n),
            .o_mean   (w_mean[c])
        );
    end

    always_comb begin
        for (int c = 0; c < CHANNELS; c++) begin
            w_mean_flat[(CHANNELS-1-c)*SAMPLE_WIDTH +: SAMPLE_WIDTH] = w_mean[c];
        end
    end

    always_comb begin
        n_state     = r_state;
        n_wr_slot   = r_wr_slot;
        n_rd_slot   = r_rd_slot;
        n_fill      = r_fill;
        n_left      = r_left;
        n_n         = r_n;
        n_rd_pend   = w_rd_issue;
        n_div_cnt   = r_div_cnt;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_data  = r_out_data;

        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    if (i_in_data.mode == MODE_PUSH) begin
                        // full: drop the oldest frame, fill stays at depth
                        n_wr_slot   = w_wr_inc;
                        n_out_valid = 1'b1;
                        n_out_data  = t_out'({ST_PUSHED, {(CHANNELS*SAMPLE_WIDTH){1'b0}}});
                        if (r_fill == CNT_W'(QUEUE_DEPTH)) begin
                            n_rd_slot         = w_rd_inc;
                            n_out_data.status = ST_DROPPED;
                        end else begin
                            n_fill = r_fill + 1'b1;
                        end
                    end else begin
                        n_left  = r_fill;
                        n_fill  = '0;
                        n_n     = '0;
                        n_state = S_DRAIN;
                    end
                end
            end
            S_DRAIN: begin
                if (w_rd_issue) begin
                    n_rd_slot = w_rd_inc;
                    n_left    = r_left - 1'b1;
                end
                if (w_ctrl.acc) begin
                    n_n = r_n + 1'b1;
                end
                if ((r_left == '0) && !r_rd_pend) begin
                    n_div_cnt = '0;
                    n_state   = (r_n == '0) ? S_FIN : S_DIV;
                end
            end
            S_DIV: begin
                n_div_cnt = r_div_cnt + 1'b1;
                if (r_div_cnt == DCW'(NUM_W - 1)) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                // hold the result until the output register is free
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    if (r_n == '0) begin
                        n_out_data = t_out'({ST_NONE, {(CHANNELS*SAMPLE_WIDTH){1'b0}}});
                    end else begin
                        n_out_data = t_out'({ST_AVG, w_mean_flat});
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wr_slot   <= '0;
            r_rd_slot   <= '0;
            r_fill      <= '0;
            r_left      <= '0;
            r_n         <= '0;
            r_rd_pend   <= 1'b0;
            r_div_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_wr_slot   <= n_wr_slot;
            r_rd_slot   <= n_rd_slot;
            r_fill      <= n_fill;
            r_left      <= n_left;
            r_n         <= n_n;
            r_rd_pend   <= n_rd_pend;
            r_div_cnt   <= n_div_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data <= n_out_data;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    `FFA_ASSERT_ALWAYS(a_fill_bound, i_clk, i_rst_n, r_fill <= CNT_W'(QUEUE_DEPTH), "fill count above depth")
    `FFA_ASSERT_IMPL(a_drain_meets_write, i_clk, i_rst_n, (r_state == S_DRAIN) && (r_left == '0), r_rd_slot == r_wr_slot, "drained buffer has read and write slots apart")
    `FFA_ASSERT_IMPL(a_div_has_count, i_clk, i_rst_n, r_state == S_DIV, r_n != '0, "divide started with no valid frame")
    `FFA_ASSERT_IMPL(a_no_read_on_accept, i_clk, i_rst_n, w_in_acc, !r_rd_pend && !w_rd_issue, "transfer accepted during a drain")
endmodule

// File: bench/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for the frame ring buffer and averager, with a cycle-free predictor.
module tb_top;
    import ffa_pkg::*;

    localparam int RING_DEPTH    = 4;
    localparam int LANE_W        = CHANNELS * SAMPLE_WIDTH;
    localparam int IDLE_LIMIT    = 2000;  // cycles with no transfer on either side
    localparam int SETTLE_CYCLES = 40;    // pause after the last result before the summary
    localparam int RANDOM_ITEMS  = 1800;
    localparam int CALM_ITEMS    = 200;

    logic i_clk       = 1'b0;
    logic i_rst_n     = 1'b0;
    logic i_in_valid  = 1'b0;
    logic i_out_ready = 1'b0;
    t_in  i_in_data   = '0;
    logic o_in_ready;
    logic o_out_valid;
    t_out o_out_data;

    frame_fifo_drop_oldest_averager_top #(
        .QUEUE_DEPTH(RING_DEPTH)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data)
    );

    always #2 i_clk = ~i_clk;

    // Predictor state: a copy of the ring, its pointers and its fill level.
    logic signed [SAMPLE_WIDTH-1:0] ring_lane [RING_DEPTH][CHANNELS];
    logic                           ring_valid [RING_DEPTH];
    int   ring_wr   = 0;
    int   ring_rd   = 0;
    int   ring_fill = 0;

    t_out expected_outcomes [$];

    // Bookkeeping for the closing summary and the verdict.
    int   errors      = 0;
    int   items_sent  = 0;
    int   push_count  = 0;
    int   drop_count  = 0;
    int   avg_count   = 0;
    int   none_count  = 0;
    int   stall_left  = 0;
    int   idle_cycles = 0;
    bit   calm        = 1'b0;   // set for the tail: no gaps and no stalls

    string lane_name [CHANNELS] = '{"accel_x", "accel_y", "accel_z",
                                    "gyro_x", "gyro_y", "gyro_z",
                                    "mag_x", "mag_y", "mag_z"};

    // Work out what one accepted transfer yields and update the copy of the ring.
    // A push overwrites the oldest frame when full; a take drains everything and
    // averages the valid frames, rounding half away from zero.
    task automatic compute_outcome(input t_in item, output t_out res);
        logic [$bits(t_in)-1:0] in_raw;
        logic [LANE_W-1:0]      out_lanes;
        logic [1:0]             st;
        longint                 sums [CHANNELS];
        longint unsigned        mag;
        longint unsigned        q;
        longint                 r;
        longint                 hi;
        int                     n;
        in_raw    = item;
        out_lanes = '0;
        hi        = (longint'(1) <<< (SAMPLE_WIDTH - 1)) - 1;
        if (item.mode == MODE_PUSH) begin
            st = ST_PUSHED;
            if (ring_fill >= RING_DEPTH) begin
                // drop the oldest frame to make room
                ring_rd = (ring_rd + 1) % RING_DEPTH;
                ring_fill--;
                st = ST_DROPPED;
                drop_count++;
            end
            for (int ch = 0; ch < CHANNELS; ch++)
                ring_lane[ring_wr][ch] = in_raw[LANE_W-1-ch*SAMPLE_WIDTH -: SAMPLE_WIDTH];
            ring_valid[ring_wr] = item.frame_valid;
            ring_wr = (ring_wr + 1) % RING_DEPTH;
            ring_fill++;
            push_count++;
        end else begin
            n = 0;
            for (int ch = 0; ch < CHANNELS; ch++)
                sums[ch] = 0;
            while (ring_fill > 0) begin
                if (ring_valid[ring_rd]) begin
                    for (int ch = 0; ch < CHANNELS; ch++)
                        sums[ch] += ring_lane[ring_rd][ch];
                    n++;
                end
                ring_rd = (ring_rd + 1) % RING_DEPTH;
                ring_fill--;
            end
            if (n == 0) begin
                st = ST_NONE;
                none_count++;
            end else begin
                st = ST_AVG;
                avg_count++;
                for (int ch = 0; ch < CHANNELS; ch++) begin
                    mag = (sums[ch] < 0) ? longint'(-sums[ch]) : longint'(sums[ch]);
                    q   = (2 * mag + n) / (2 * n);
                    if (q > hi + 1)
                        q = hi + 1;
                    r = (sums[ch] < 0) ? -longint'(q) : longint'(q);
                    if (r > hi)
                        r = hi;
                    if (r < -hi - 1)
                        r = -hi - 1;
                    out_lanes[LANE_W-1-ch*SAMPLE_WIDTH -: SAMPLE_WIDTH] = r[SAMPLE_WIDTH-1:0];
                end
            end
        end
        res = {st, out_lanes};
    endtask

    // Favour the extremes, zero and minus one; otherwise any value.
    function automatic logic [SAMPLE_WIDTH-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0:       return S_MAX;
            1:       return S_MIN;
            2:       return '0;
            3:       return '1;
            default: return SAMPLE_WIDTH'($urandom);
        endcase
    endfunction

    function automatic t_in frame_of(input logic mode, input logic vld);
        logic [$bits(t_in)-1:0] raw;
        t_in                    f;
        for (int ch = 0; ch < CHANNELS; ch++)
            raw[LANE_W-1-ch*SAMPLE_WIDTH -: SAMPLE_WIDTH] = pick_sample();
        f             = raw[$bits(t_in)-1:0];
        f.mode        = mode;
        f.frame_valid = vld;
        return f;
    endfunction

    // A push with the same value on all nine channels.
    function automatic t_in flat_frame(input logic vld, input logic [SAMPLE_WIDTH-1:0] value);
        t_in f;
        f = '0;
        f.mode        = MODE_PUSH;
        f.frame_valid = vld;
        f = {f.mode, f.frame_valid, {CHANNELS{value}}};
        return f;
    endfunction

    function automatic t_in take_item();
        // a take ignores the samples and the valid mark, so scramble them
        return frame_of(MODE_TAKE, 1'($urandom_range(0, 1)));
    endfunction

    // Offer one item, optionally after a gap, and hold it until the transfer.
    // Valid is left high on return so the next item can follow back to back.
    task automatic send_frame(input t_in item);
        t_out res;
        int   gap;
        if (!calm && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 5);
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        do @(posedge i_clk); while (!o_in_ready);
        compute_outcome(item, res);
        expected_outcomes.push_back(res);
        items_sent++;
    endtask

    // Hold the sender off until every outstanding result has been read.
    task automatic hold_until_drained();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (expected_outcomes.size() != 0)
            @(posedge i_clk);
    endtask

    // Mostly well-formed bursts: a few pushes, then a take. The rest is noise.
    task automatic random_traffic(input int count, input bit with_pause);
        int  stop_at;
        int  pause_at;
        int  pushes;
        bit  paused;
        stop_at  = items_sent + count;
        pause_at = items_sent + count / 2;
        paused   = 1'b0;
        while (items_sent < stop_at) begin
            if (with_pause && !paused && items_sent >= pause_at) begin
                hold_until_drained();
                paused = 1'b1;
            end
            if ($urandom_range(0, 9) < 8) begin
                pushes = $urandom_range(0, 6);
                repeat (pushes)
                    send_frame(frame_of(MODE_PUSH, 1'($urandom_range(0, 3) != 0)));
                send_frame(take_item());
            end else begin
                send_frame(frame_of(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
            end
        end
    endtask

    task automatic test_empty_take();
        send_frame(take_item());
    endtask

    task automatic test_sample_extremes();
        // max and min together average to minus one half, rounded away to minus one
        send_frame(flat_frame(1'b1, S_MAX));
        send_frame(flat_frame(1'b1, S_MIN));
        send_frame(take_item());
        send_frame(flat_frame(1'b1, S_MIN));
        send_frame(take_item());
        send_frame(flat_frame(1'b1, S_MAX));
        send_frame(take_item());
    endtask

    task automatic test_drop_oldest();
        // six pushes into four slots: the last two report a dropped frame
        for (int k = 0; k < 6; k++)
            send_frame(flat_frame(1'b1, SAMPLE_WIDTH'(k * 5000 - 12000)));
        send_frame(take_item());
    endtask

    task automatic test_no_valid_frame();
        send_frame(flat_frame(1'b0, S_MAX));
        send_frame(flat_frame(1'b0, S_MIN));
        send_frame(take_item());
        send_frame(take_item());
    endtask

    task automatic test_rounding_ties();
        t_in f;
        // halves on both sides of zero
        f = frame_of(MODE_PUSH, 1'b1);
        f.accel_x = SAMPLE_WIDTH'(1);
        f.accel_y = SAMPLE_WIDTH'(-1);
        f.accel_z = SAMPLE_WIDTH'(0);
        f.gyro_x  = SAMPLE_WIDTH'(0);
        send_frame(f);
        f = frame_of(MODE_PUSH, 1'b1);
        f.accel_x = SAMPLE_WIDTH'(2);
        f.accel_y = SAMPLE_WIDTH'(-2);
        f.accel_z = SAMPLE_WIDTH'(1);
        f.gyro_x  = SAMPLE_WIDTH'(-1);
        send_frame(f);
        send_frame(take_item());
        // an invalid frame between two valid ones must not count
        f = frame_of(MODE_PUSH, 1'b1);
        f.accel_x = SAMPLE_WIDTH'(1);
        f.accel_y = SAMPLE_WIDTH'(-1);
        send_frame(f);
        send_frame(flat_frame(1'b0, S_MAX));
        f = frame_of(MODE_PUSH, 1'b1);
        f.accel_x = SAMPLE_WIDTH'(0);
        f.accel_y = SAMPLE_WIDTH'(0);
        send_frame(f);
        send_frame(take_item());
    endtask

    task automatic test_random_traffic();
        random_traffic(RANDOM_ITEMS, 1'b1);
    endtask

    task automatic test_calm_tail();
        calm = 1'b1;
        random_traffic(CALM_ITEMS, 1'b0);
    endtask

    // Result side: stall in random bursts, never in the tail.
    always @(negedge i_clk) begin
        if (stall_left == 0 && !calm && $urandom_range(0, 5) == 0)
            stall_left = $urandom_range(1, 5);
        if (stall_left > 0) begin
            i_out_ready <= 1'b0;
            stall_left--;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // Compare each result transfer with the oldest expectation, field by field.
    always @(posedge i_clk) begin
        logic [$bits(t_out)-1:0] want_raw;
        logic [$bits(t_out)-1:0] got_raw;
        t_out                    want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_outcomes.size() == 0) begin
                $display("%0t: unexpected result, status %0d", $time, o_out_data.status);
                errors++;
            end else begin
                want     = expected_outcomes.pop_front();
                want_raw = want;
                got_raw  = o_out_data;
                if (o_out_data.status !== want.status) begin
                    $display("%0t: status expected %0d, got %0d",
                             $time, want.status, o_out_data.status);
                    errors++;
                end
                for (int ch = 0; ch < CHANNELS; ch++) begin
                    if (got_raw[LANE_W-1-ch*SAMPLE_WIDTH -: SAMPLE_WIDTH] !==
                        want_raw[LANE_W-1-ch*SAMPLE_WIDTH -: SAMPLE_WIDTH]) begin
                        $display("%0t: avg_%s expected %0d, got %0d", $time, lane_name[ch],
                                 $signed(want_raw[LANE_W-1-ch*SAMPLE_WIDTH -: SAMPLE_WIDTH]),
                                 $signed(got_raw[LANE_W-1-ch*SAMPLE_WIDTH -: SAMPLE_WIDTH]));
                        errors++;
                    end
                end
            end
        end
    end

    // Watchdog: end the run if neither side transfers for too long.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
                $display("*** FAILED ***");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial begin
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_take();
        test_sample_extremes();
        test_drop_oldest();
        test_no_valid_frame();
        test_rounding_ties();
        test_random_traffic();
        test_calm_tail();

        // Drop valid, wait for the last results, then let the block settle.
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (expected_outcomes.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Run covered %0d transfers: %0d pushes, %0d of them overwriting the oldest frame,",
                 items_sent, push_count, drop_count);
        $display("%0d takes with a mean and %0d takes with nothing to average; %0d mismatches.",
                 avg_count, none_count, errors);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
